### rtl/core/bmc_pkg.sv
// Shared types, constants and helpers for the bracket match checker.
// No dependencies; used by bmc_stack_cell and bracket_match_checker_core.
package bmc_pkg;

   localparam int STACK_DEPTH_DEF = 128;

   localparam int SYMBOL_W = 8;
   localparam int STATUS_W = 3;
   localparam int POINTS_W = 16;
   localparam int TOTAL_W  = 32;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_KINDS = 4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAREN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SQUARE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURLY  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE  = 2'd3;

   // bracket kinds
   localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

   localparam logic [POINTS_W-1:0] PAREN_POINTS_RST  = 16'd3;
   localparam logic [POINTS_W-1:0] SQUARE_POINTS_RST = 16'd57;
   localparam logic [POINTS_W-1:0] CURLY_POINTS_RST  = 16'd1197;
   localparam logic [POINTS_W-1:0] ANGLE_POINTS_RST  = 16'd25137;

   typedef struct packed {
      logic              is_open;
      logic              is_close;
      logic [KIND_W-1:0] kind;
   } sym_class_type;

   // shift command broadcast along the cell row
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctrl_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POINTS_W-1:0] points;
      logic [TOTAL_W-1:0]  total;
   } rsp_type;

   function automatic sym_class_type classify(input logic [SYMBOL_W-1:0] sym);
      sym_class_type c;
      c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
      case (sym)
         8'h28: c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
         8'h5B: c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
         8'h7B: c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_CURLY};
         8'h3C: c = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_ANGLE};
         8'h29: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
         8'h5D: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
         8'h7D: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_CURLY};
         8'h3E: c = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_ANGLE};
         default: c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_PAREN};
      endcase
      return c;
   endfunction

endpackage

### rtl/core/bmc_stack_cell.sv
// One entry of the shifting bracket stack: holds a 2-bit opener kind.
// Depends on bmc_pkg for the kind width and the shift command type.
module bmc_stack_cell (
   input  logic                          clock,
   input  bmc_pkg::stk_ctrl_type         ctrl,
   input  logic [bmc_pkg::KIND_W-1:0]    from_above,
   input  logic [bmc_pkg::KIND_W-1:0]    from_below,
   output logic [bmc_pkg::KIND_W-1:0]    kind
);

   logic [bmc_pkg::KIND_W-1:0] kind_ff;
   logic [bmc_pkg::KIND_W-1:0] kind_in;

   // push: take the neighbor above; pop: take the neighbor below; else hold
   always_comb begin
      kind_in = kind_ff;
      if (ctrl.push) begin
         kind_in = from_above;
      end else if (ctrl.pop) begin
         kind_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

### rtl/core/bracket_match_checker_core.sv
// Balanced-bracket checker for ( [ { < : one text byte per transaction in, one
// status transaction out for every byte, one transaction per clock cycle
// sustained while the receiver does not stall. The stack is a row of
// STACK_DEPTH shifting cells with the top of stack in cell 0, so each byte
// does its push or pop in the cycle it is accepted and the next byte may
// follow at once. Results pass through an output register backed by a
// one-entry skid buffer; req_stall rises only when both are full. The csr
// channel is always ready; write it only while no transaction is in flight.
// There is no clearing pass after reset. Depends on bmc_pkg and bmc_stack_cell.
module bracket_match_checker_core #(
   parameter int STACK_DEPTH = bmc_pkg::STACK_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input byte channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bmc_pkg::SYMBOL_W-1:0]      req_symbol,
   input  logic                              req_line_end,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bmc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bmc_pkg::POINTS_W-1:0]      rsp_points,
   output logic [bmc_pkg::TOTAL_W-1:0]       rsp_total_score,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bmc_pkg::POINTS_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   // ------------------------------------------------------------------
   // Points registers, one per bracket kind
   // ------------------------------------------------------------------
   logic [bmc_pkg::POINTS_W-1:0] points_ff [bmc_pkg::NUM_KINDS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff[bmc_pkg::CSR_PAREN]  <= bmc_pkg::PAREN_POINTS_RST;
         points_ff[bmc_pkg::CSR_SQUARE] <= bmc_pkg::SQUARE_POINTS_RST;
         points_ff[bmc_pkg::CSR_CURLY]  <= bmc_pkg::CURLY_POINTS_RST;
         points_ff[bmc_pkg::CSR_ANGLE]  <= bmc_pkg::ANGLE_POINTS_RST;
      end else if (csr_valid && csr_ready) begin
         points_ff[csr_index] <= csr_wdata;
      end
   end

   // ------------------------------------------------------------------
   // Line state
   // ------------------------------------------------------------------
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         stopped_ff, stopped_in;
   logic [bmc_pkg::TOTAL_W-1:0]  score_ff, score_in;

   logic                         accept;
   bmc_pkg::sym_class_type       cls;
   bmc_pkg::stk_ctrl_type        stk_ctrl;
   logic [bmc_pkg::KIND_W-1:0]   top_kind;
   bmc_pkg::rsp_type             result;
   logic [bmc_pkg::POINTS_W-1:0] kind_points;
   logic [bmc_pkg::TOTAL_W:0]    sum_wide;

   assign accept      = req_valid && !req_stall;
   assign cls         = bmc_pkg::classify(req_symbol);
   assign kind_points = points_ff[cls.kind];
   assign sum_wide    = {1'b0, score_ff} + {{(bmc_pkg::TOTAL_W + 1 - bmc_pkg::POINTS_W){1'b0}},
                                            kind_points};

   always_comb begin
      count_in      = count_ff;
      stopped_in    = stopped_ff;
      score_in      = score_ff;
      stk_ctrl      = '{push: 1'b0, pop: 1'b0};
      result.status = bmc_pkg::ST_OK;
      result.points = '0;
      if (accept) begin
         if (stopped_ff) begin
            // drop the rest of a stopped line
            result.status = bmc_pkg::ST_STOPPED;
         end else if (cls.is_open) begin
            if (count_ff == CNT_FULL) begin
               result.status = bmc_pkg::ST_OVERFLOW;
               stopped_in    = 1'b1;
            end else begin
               stk_ctrl.push = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
         end else if (cls.is_close) begin
            if (count_ff == '0) begin
               result.status = bmc_pkg::ST_UNMATCHED;
               stopped_in    = 1'b1;
            end else begin
               stk_ctrl.pop = 1'b1;
               count_in     = count_ff - CNT_W'(1);
               if (top_kind != cls.kind) begin
                  result.status = bmc_pkg::ST_MISMATCH;
                  result.points = kind_points;
                  stopped_in    = 1'b1;
                  // saturate at all ones
                  score_in = sum_wide[bmc_pkg::TOTAL_W] ? '1 : sum_wide[bmc_pkg::TOTAL_W-1:0];
               end
            end
         end
         if (req_line_end) begin
            count_in   = '0;
            stopped_in = 1'b0;
         end
      end
      result.total = score_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         stopped_ff <= 1'b0;
         score_ff   <= '0;
      end else begin
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         score_ff   <= score_in;
      end
   end

   // ------------------------------------------------------------------
   // Stack: row of shifting cells, cell 0 is the top of stack
   // ------------------------------------------------------------------
   logic [bmc_pkg::KIND_W-1:0] cell_kind [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [bmc_pkg::KIND_W-1:0] above;
      logic [bmc_pkg::KIND_W-1:0] below;
      if (i == 0) begin : g_top
         assign above = cls.kind;
      end else begin : g_mid
         assign above = cell_kind[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = cell_kind[i];
      end else begin : g_up
         assign below = cell_kind[i+1];
      end
      bmc_stack_cell u_cell (
         .clock      (clock),
         .ctrl       (stk_ctrl),
         .from_above (above),
         .from_below (below),
         .kind       (cell_kind[i])
      );
   end

   assign top_kind = cell_kind[0];

   // ------------------------------------------------------------------
   // Output register with one-entry skid buffer
   // ------------------------------------------------------------------
   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   bmc_pkg::rsp_type out_ff, out_in;
   bmc_pkg::rsp_type skid_ff, skid_in;
   logic             out_free;

   assign req_stall = skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // advance the parked transaction
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         // hold the new result until the output drains
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_points      = out_ff.points;
   assign rsp_total_score = out_ff.total;

endmodule

### verif/bmc_tb_pkg.sv
// Bracket characters for the bracket match checker testbench, indexed by kind code.
// The order follows the kind codes of bmc_pkg; used by the checker and the top.
package bmc_tb_pkg;

   localparam logic [7:0] OPEN_SYM  [4] = '{8'h28, 8'h5B, 8'h7B, 8'h3C};
   localparam logic [7:0] CLOSE_SYM [4] = '{8'h29, 8'h5D, 8'h7D, 8'h3E};

endpackage

### verif/bmc_score_checker.sv
// Scoreboard for bracket_match_checker_core: tracks the bracket stack and the score,
// predicts every result and compares it. Depends on bmc_pkg and bmc_tb_pkg.
module bmc_score_checker #(
   parameter int STACK_DEPTH = bmc_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [bmc_pkg::SYMBOL_W-1:0]  req_symbol,
   input  logic                          req_line_end,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [bmc_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [bmc_pkg::POINTS_W-1:0]  rsp_points,
   input  logic [bmc_pkg::TOTAL_W-1:0]   rsp_total_score,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [bmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bmc_pkg::POINTS_W-1:0]  csr_wdata,
   output int                            failures,
   output int                            in_flight
);

   import bmc_pkg::*;
   import bmc_tb_pkg::*;

   logic [KIND_W-1:0]   open_kinds [STACK_DEPTH];
   int                  depth;
   logic                stopped;
   logic [TOTAL_W-1:0]  running_total;
   logic [POINTS_W-1:0] kind_points [NUM_KINDS];
   rsp_type             expected_q [$];
   int                  errors_seen;

   // Work out the result of one byte and advance the tracked line state.
   function automatic rsp_type score_byte(input logic [SYMBOL_W-1:0] sym,
                                          input logic line_last);
      rsp_type           r;
      logic              is_open;
      logic              is_close;
      logic [KIND_W-1:0] kind;
      logic [TOTAL_W:0]  widened;
      r.status = ST_OK;
      r.points = '0;
      is_open  = 1'b0;
      is_close = 1'b0;
      kind     = KIND_PAREN;
      for (int k = 0; k < NUM_KINDS; k++) begin
         if (sym == OPEN_SYM[k]) begin
            is_open = 1'b1;
            kind    = KIND_W'(k);
         end
         if (sym == CLOSE_SYM[k]) begin
            is_close = 1'b1;
            kind     = KIND_W'(k);
         end
      end
      if (stopped) begin
         r.status = ST_STOPPED;
      end else if (is_open) begin
         if (depth >= STACK_DEPTH) begin
            r.status = ST_OVERFLOW;
            stopped  = 1'b1;
         end else begin
            open_kinds[depth] = kind;
            depth++;
         end
      end else if (is_close) begin
         if (depth == 0) begin
            r.status = ST_UNMATCHED;
            stopped  = 1'b1;
         end else begin
            depth--;
            if (open_kinds[depth] != kind) begin
               r.status      = ST_MISMATCH;
               r.points      = kind_points[kind];
               widened       = {1'b0, running_total} + (TOTAL_W+1)'(r.points);
               running_total = widened[TOTAL_W] ? '1 : widened[TOTAL_W-1:0];
               stopped       = 1'b1;
            end
         end
      end
      if (line_last) begin
         depth   = 0;
         stopped = 1'b0;
      end
      r.total = running_total;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         depth                   = 0;
         stopped                 = 1'b0;
         running_total           = '0;
         kind_points[KIND_PAREN]  = PAREN_POINTS_RST;
         kind_points[KIND_SQUARE] = SQUARE_POINTS_RST;
         kind_points[KIND_CURLY]  = CURLY_POINTS_RST;
         kind_points[KIND_ANGLE]  = ANGLE_POINTS_RST;
         expected_q.delete();
      end else begin
         // results first: a result never belongs to a byte taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            got = '{status: rsp_status, points: rsp_points, total: rsp_total_score};
            if (expected_q.size() == 0) begin
               $error("result with no byte outstanding: status %0d, points %0d, total %0d",
                      got.status, got.points, got.total);
               errors_seen++;
            end else begin
               want = expected_q.pop_front();
               if (got.status != want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  errors_seen++;
               end
               if (got.points != want.points) begin
                  $error("points: expected %0d, actual %0d", want.points, got.points);
                  errors_seen++;
               end
               if (got.total != want.total) begin
                  $error("total_score: expected %0d, actual %0d", want.total, got.total);
                  errors_seen++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            kind_points[csr_index] = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(score_byte(req_symbol, req_line_end));
         end
      end
      in_flight <= expected_q.size();
      failures  <= errors_seen;
   end

endmodule

### verif/testbench.sv
// Top of the bracket_match_checker_core testbench: clock, reset, stimulus and verdict.
// Depends on bmc_pkg, bmc_tb_pkg, bmc_score_checker and the core itself.
module testbench;

   import bmc_pkg::*;
   import bmc_tb_pkg::*;

   localparam int STACK_DEPTH   = STACK_DEPTH_DEF;
   localparam int CLOCK_PERIOD  = 20;
   localparam int IDLE_PERCENT  = 13;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 10;
   localparam int PHASE_BYTES   = 50;
   localparam int LIMIT_CYCLES  = 20000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [SYMBOL_W-1:0]   req_symbol   = '0;
   logic                  req_line_end = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [POINTS_W-1:0]   rsp_points;
   logic [TOTAL_W-1:0]    rsp_total_score;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PAREN;
   logic [POINTS_W-1:0]   csr_wdata = '0;

   int                    failures;
   int                    in_flight;

   // stimulus flags, changed only with nonblocking assignments at the clock edge
   logic                  calm       = 1'b0;  // no idling on either side
   logic                  hold_armed = 1'b0;  // ask the receiver for one long hold-off

   int                    bytes_sent;
   int                    lines_sent;
   int                    settings_used;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   bracket_match_checker_core #(
      .STACK_DEPTH (STACK_DEPTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_line_end    (req_line_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_points      (rsp_points),
      .rsp_total_score (rsp_total_score),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   bmc_score_checker #(
      .STACK_DEPTH (STACK_DEPTH)
   ) score_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_symbol      (req_symbol),
      .req_line_end    (req_line_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_points      (rsp_points),
      .rsp_total_score (rsp_total_score),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .in_flight       (in_flight)
   );

   // Offer one byte and hold it until the core takes the transaction. The stall
   // read right after the edge is the value the core saw at that edge.
   task automatic send_byte(input logic [SYMBOL_W-1:0] sym, input logic line_last);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_symbol   <= sym;
      req_line_end <= line_last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (line_last) lines_sent++;
   endtask

   task automatic send_text(input string txt, input logic close_line);
      for (int i = 0; i < txt.len(); i++) begin
         send_byte(txt[i], close_line && (i == txt.len() - 1));
      end
   endtask

   // Drop valid and wait until every result is back; only then is the core idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
   endtask

   // Leave valid high between writes so it is never lowered and raised in one step.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [POINTS_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_points(input logic [POINTS_W-1:0] paren, input logic [POINTS_W-1:0] square,
                             input logic [POINTS_W-1:0] curly, input logic [POINTS_W-1:0] angle);
      write_reg(CSR_PAREN, paren);
      write_reg(CSR_SQUARE, square);
      write_reg(CSR_CURLY, curly);
      write_reg(CSR_ANGLE, angle);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // One line: mostly properly nested brackets with letters mixed in, some of
   // them broken by a wrong closer or a stray closer, the rest raw noise.
   task automatic send_random_line();
      logic [SYMBOL_W-1:0] bytes_q [$];
      int                  closer_at [$];
      logic [KIND_W-1:0]   pending [$];
      logic [KIND_W-1:0]   k;
      int                  len;
      int                  style;
      int                  roll;
      int                  pos;
      len   = $urandom_range(14, 1);
      style = $urandom_range(99);
      if (style < 75) begin
         repeat (len) begin
            roll = $urandom_range(9);
            if (roll < 4 && pending.size() > 0) begin
               closer_at.push_back(bytes_q.size());
               bytes_q.push_back(CLOSE_SYM[pending.pop_back()]);
            end else if (roll < 8) begin
               k = KIND_W'($urandom_range(3));
               pending.push_back(k);
               bytes_q.push_back(OPEN_SYM[k]);
            end else begin
               bytes_q.push_back(SYMBOL_W'($urandom_range(8'h7A, 8'h61)));
            end
         end
         // close what is still open, most of the time
         if ($urandom_range(9) < 7) begin
            while (pending.size() > 0) begin
               closer_at.push_back(bytes_q.size());
               bytes_q.push_back(CLOSE_SYM[pending.pop_back()]);
            end
         end
         if (style >= 45 && style < 60 && closer_at.size() > 0) begin
            // swap one closer for a closer of another kind
            pos = closer_at[$urandom_range(closer_at.size() - 1)];
            k   = KIND_PAREN;
            for (int j = 0; j < NUM_KINDS; j++) begin
               if (bytes_q[pos] == CLOSE_SYM[j]) k = KIND_W'(j);
            end
            k = k + KIND_W'($urandom_range(3, 1));
            bytes_q[pos] = CLOSE_SYM[k];
         end else if (style >= 60) begin
            bytes_q.push_back(CLOSE_SYM[$urandom_range(3)]);
         end
      end else begin
         repeat (len) begin
            if ($urandom_range(1) == 0) begin
               bytes_q.push_back(SYMBOL_W'($urandom_range(255)));
            end else if ($urandom_range(1) == 0) begin
               bytes_q.push_back(OPEN_SYM[$urandom_range(3)]);
            end else begin
               bytes_q.push_back(CLOSE_SYM[$urandom_range(3)]);
            end
         end
      end
      foreach (bytes_q[i]) begin
         send_byte(bytes_q[i], i == bytes_q.size() - 1);
      end
   endtask

   task automatic run_random(input int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) send_random_line();
   endtask

   // Fill the stack to the brim, pop one, push back to full, then overflow it;
   // the trailing bytes land on a stopped line.
   task automatic send_deep_line();
      logic [KIND_W-1:0] k;
      k = KIND_PAREN;
      repeat (STACK_DEPTH) begin
         k = KIND_W'($urandom_range(3));
         send_byte(OPEN_SYM[k], 1'b0);
      end
      send_byte(CLOSE_SYM[k], 1'b0);
      send_byte(OPEN_SYM[$urandom_range(3)], 1'b0);
      send_byte(OPEN_SYM[$urandom_range(3)], 1'b0);
      send_byte(8'h71, 1'b0);
      send_byte(CLOSE_SYM[$urandom_range(3)], 1'b1);
   endtask

   // Receiver: random stalls, none while calm, and one long hold-off once armed
   // so the output buffers fill and the core pushes back on its input.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   initial begin
      bytes_sent    = 0;
      lines_sent    = 0;
      settings_used = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: every pair matched, a mismatch of each closer kind, a stopped
      // tail, a closer on an empty stack, a line end on an opener and the
      // extreme byte values, all at the reset point values.
      send_text("([{<>}])", 1'b1);
      send_text("(]x", 1'b0);
      send_byte(8'hFF, 1'b1);
      send_text("[)", 1'b1);
      send_text("{>", 1'b1);
      send_text("<}", 1'b1);
      send_text(")(", 1'b1);
      send_text("(", 1'b1);
      send_text(")", 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b1);
      run_random(PHASE_BYTES);

      // zero points: mismatches still stop the line but add nothing
      wait_idle();
      set_points('0, '0, '0, '0);
      send_deep_line();
      run_random(PHASE_BYTES);

      // full-scale points, with the long receiver hold-off during this phase
      wait_idle();
      set_points('1, '1, '1, '1);
      hold_armed <= 1'b1;
      run_random(PHASE_BYTES);

      // random points, no idling on either side
      wait_idle();
      set_points(POINTS_W'($urandom), POINTS_W'($urandom),
                 POINTS_W'($urandom), POINTS_W'($urandom));
      calm <= 1'b1;
      run_random(PHASE_BYTES);

      wait_idle();
      calm <= 1'b0;
      set_points(16'd1, '1, '0, 16'h8000);
      run_random(PHASE_BYTES);

      wait_idle();
      set_points('1, '1, '1, '1);
      run_random(PHASE_BYTES / 2);

      wait_idle();
      set_points(POINTS_W'($urandom), POINTS_W'($urandom),
                 POINTS_W'($urandom), POINTS_W'($urandom));
      run_random(PHASE_BYTES / 2);

      // let the last results settle before the verdict
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d bytes in %0d lines under %0d point settings.",
               bytes_sent, lines_sent, settings_used);
      $display("Covered matched nesting, mismatches, stray closers and overflow at depth %0d.",
               STACK_DEPTH);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $error("watchdog expired with %0d results outstanding", in_flight);
      $display("Test completed with failures");
      $finish;
   end

endmodule
